// File: hw/rtl/hpg_pkg.sv
// Hotplug governor package: field widths, event/action codes, state and result structs,
// and the profile threshold table. No dependencies.
`default_nettype none

package hpg_pkg;

    localparam int AVG_W   = 20;   // load fields
    localparam int KIND_W  = 3;
    localparam int MASK_W  = 4;
    localparam int ACT_W   = 3;
    localparam int LVL_W   = 3;
    localparam int HYST_W  = 5;
    localparam int PROF_W  = 3;
    localparam int IDLE_W  = 5;
    localparam int PERS_W  = 4;
    localparam int THR_W   = 6;    // scaled level threshold, max 56 at the top of the cap range
    localparam int SUM_W   = 7;    // threshold plus hysteresis
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W   = 12;
    localparam int LVL_DIV = 100000;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SCREEN_ON  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SCREEN_OFF = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOUCH      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LAZY_ENTER = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LAZY_EXIT  = 3'd5;

    // actions
    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ALL_UP   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DOWN_SEL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ALL_DOWN = 3'd3;
    localparam logic [ACT_W-1:0] ACT_BOOST    = 3'd4;

    // profiles
    localparam logic [PROF_W-1:0] PROF_CONSERV  = 3'd2;
    localparam logic [PROF_W-1:0] PROF_ECO      = 3'd3;  // first single-threshold profile
    localparam logic [PROF_W-1:0] PROF_LAZY     = 3'd6;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLUG_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_THR  = 3'd4;

    typedef logic [7:0][2:0][RAW_W-1:0] t_raw_tab;
    typedef logic [7:0][2:0][THR_W-1:0] t_thr_tab;

    // per-profile level thresholds before scaling by the thread cap
    localparam t_raw_tab PROF_RAW = '{
        '{12'd0,    12'd0,    12'd0},     // 7: unused, acts as disable
        '{12'd2350, 12'd1875, 12'd995},   // 6: lazy
        '{12'd0,    12'd0,    12'd0},     // 5: disable
        '{12'd0,    12'd0,    12'd750},   // 4: eco extreme
        '{12'd0,    12'd0,    12'd380},   // 3: eco
        '{12'd2125, 12'd1625, 12'd875},   // 2: conservative
        '{12'd875,  12'd625,  12'd380},   // 1: performance
        '{12'd1125, 12'd875,  12'd625}    // 0: balance
    };

    // elaboration-time scaling of the table by the thread cap
    function automatic t_thr_tab thr_tab(int unsigned cap);
        t_thr_tab tab;
        int unsigned v;
        for (int p = 0; p < 8; p++) begin
            for (int l = 0; l < 3; l++) begin
                v = (cap * 32'(PROF_RAW[p][l]) * 4) / LVL_DIV;
                tab[p][l] = THR_W'(v);
            end
        end
        return tab;
    endfunction

    typedef struct packed {
        logic              plug_en;
        logic              touch_en;
    } t_ctrl_cfg;

    typedef struct packed {
        logic [LVL_W-1:0]  last_level;
        logic [IDLE_W-1:0] idle_ticks;
        logic [PERS_W-1:0] persist_ticks;
        logic              screen_off;
        logic              touch_seen;
        logic              lazy_active;
        logic [PROF_W-1:0] lazy_profile;
    } t_gov_state;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [MASK_W-1:0] down_mask;
        logic [LVL_W-1:0]  load_level;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/hpg_in_if.sv
// Input event channel: valid/ready plus one event word.
// Depends on hpg_pkg.
`default_nettype none

interface hpg_in_if import hpg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [AVG_W-1:0]  avg_load;
    logic [MASK_W-1:0] online_mask;
    logic              video_flag;
    logic [AVG_W-1:0]  load_core1;
    logic [AVG_W-1:0]  load_core2;
    logic [AVG_W-1:0]  load_core3;

    modport source (output valid, kind, avg_load, online_mask, video_flag,
                    load_core1, load_core2, load_core3, input ready);
    modport sink   (input valid, kind, avg_load, online_mask, video_flag,
                    load_core1, load_core2, load_core3, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hpg_out_if.sv
// Result channel: valid/ready plus one decision word.
// Depends on hpg_pkg.
`default_nettype none

interface hpg_out_if import hpg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [MASK_W-1:0] down_mask;
    logic [LVL_W-1:0]  load_level;

    modport source (output valid, action, down_mask, load_level, input ready);
    modport sink   (input valid, action, down_mask, load_level, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hpg_lvl_lane.sv
// One threshold lane: compares the average load against one scaled level threshold.
// Depends on hpg_pkg.
`default_nettype none

module hpg_lvl_lane import hpg_pkg::*; #(
    parameter int FRAC_BITS = 11,
    parameter int STD_SHIFT = 3
) (
    input  wire logic [AVG_W-1:0]  i_avg,
    input  wire logic [THR_W-1:0]  i_thr,
    input  wire logic [HYST_W-1:0] i_hyst,
    input  wire logic              i_add_hyst,
    input  wire logic              i_eco,
    output logic                   o_above
);
    localparam int CMP_W  = (AVG_W > SUM_W + FRAC_BITS) ? AVG_W : SUM_W + FRAC_BITS;
    localparam int SH_STD = FRAC_BITS - STD_SHIFT;
    localparam int SH_ECO = FRAC_BITS - 1;

    logic [SUM_W-1:0] w_sum;
    logic [CMP_W-1:0] w_lim;

    always_comb begin
        w_sum = SUM_W'(i_thr) + (i_add_hyst ? SUM_W'(i_hyst) : SUM_W'(0));
        w_lim = i_eco ? (CMP_W'(w_sum) << SH_ECO) : (CMP_W'(w_sum) << SH_STD);
        o_above = CMP_W'(i_avg) > w_lim;
    end
endmodule

`default_nettype wire

// File: hw/rtl/hpg_core_lane.sv
// One core lane: flags an online core whose load is under the take-down threshold.
// Depends on hpg_pkg.
`default_nettype none

module hpg_core_lane import hpg_pkg::*; (
    input  wire logic             i_online,
    input  wire logic [AVG_W-1:0] i_load,
    input  wire logic [AVG_W-1:0] i_thr,
    output logic                  o_down
);
    assign o_down = i_online && (i_load < i_thr);
endmodule

`default_nettype wire

// File: hw/rtl/hpg_ctrl.sv
// Merge stage: folds lane results into the load level, decides the action and next state.
// Depends on hpg_pkg.
`default_nettype none

module hpg_ctrl import hpg_pkg::*; #(
    parameter int CORES      = 4,
    parameter int IDLE_LIMIT = 19,
    parameter int BUSY_TICKS = 13
) (
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic              i_video,
    input  wire logic [2:0]        i_above,
    input  wire logic              i_eco,
    input  wire logic [MASK_W-1:0] i_down,
    input  wire t_ctrl_cfg         i_cfg,
    input  wire t_gov_state        i_state,
    output t_gov_state             o_state,
    output t_result                o_result
);
    localparam logic [IDLE_W-1:0] IDLE_MAX  = IDLE_W'(IDLE_LIMIT);
    localparam logic [PERS_W-1:0] BUSY_LOAD = PERS_W'(BUSY_TICKS);
    localparam bit                MULTI     = (CORES > 2);

    logic [LVL_W-1:0]  w_level;
    logic [IDLE_W-1:0] w_idle;
    logic [PERS_W-1:0] w_pers;

    always_comb begin
        // level = first threshold not exceeded; single-threshold tables and builds of two cores or fewer stop at 2
        if (!i_above[0])
            w_level = LVL_W'(1);
        else if (!MULTI || i_eco || !i_above[1])
            w_level = LVL_W'(2);
        else if (!i_above[2])
            w_level = LVL_W'(3);
        else
            w_level = LVL_W'(4);

        w_pers = (i_state.persist_ticks != '0) ? i_state.persist_ticks - PERS_W'(1)
                                               : i_state.persist_ticks;
        w_idle = (i_state.idle_ticks < IDLE_MAX) ? i_state.idle_ticks + IDLE_W'(1)
                                                 : i_state.idle_ticks;

        o_state  = i_state;
        o_result = '0;

        case (i_kind)
            KIND_TICK: begin
                if (i_cfg.plug_en) begin
                    o_result.load_level = w_level;
                    o_state.last_level  = w_level;
                    if (!i_state.screen_off) begin
                        o_state.persist_ticks = w_pers;
                        if (w_level == LVL_W'(1)) begin
                            o_state.idle_ticks = w_idle;
                            if (w_idle == IDLE_MAX && w_pers == '0) begin
                                o_result.action    = ACT_DOWN_SEL;
                                o_result.down_mask = i_down;
                            end
                        end else begin
                            o_state.idle_ticks = '0;
                            o_result.action    = ACT_ALL_UP;
                        end
                    end
                end
            end
            KIND_SCREEN_ON: begin
                if (i_cfg.plug_en) begin
                    o_state.persist_ticks = BUSY_LOAD;
                    o_state.screen_off    = 1'b0;
                    o_result.action       = ACT_ALL_UP;
                end
            end
            KIND_SCREEN_OFF: begin
                if (i_cfg.plug_en) begin
                    o_state.screen_off = 1'b1;
                    o_state.touch_seen = 1'b0;
                    o_result.action    = ACT_ALL_DOWN;
                end
            end
            KIND_TOUCH: begin
                if (i_cfg.plug_en && i_cfg.touch_en && !i_state.lazy_active
                    && i_state.screen_off && !i_state.touch_seen) begin
                    o_state.idle_ticks = '0;
                    o_state.touch_seen = 1'b1;
                    o_result.action    = ACT_BOOST;
                end
            end
            KIND_LAZY_ENTER: begin
                if (!i_state.lazy_active) begin
                    o_state.lazy_active  = 1'b1;
                    o_state.lazy_profile = i_video ? PROF_CONSERV : PROF_LAZY;
                end
            end
            KIND_LAZY_EXIT: begin
                o_state.lazy_active = 1'b0;
            end
            default: begin
            end
        endcase
    end
endmodule

`default_nettype wire

// File: hw/rtl/core_hotplug_governor.sv
// Core hotplug governor top: config registers, threshold and core lanes, merge, output skid.
// An accepted event word's decision word is registered in the output register, or in the skid if the output is stalled.
// Throughput: one word per cycle while the skid is empty; governor state updates in the accepting cycle.
// A two-entry output register/skid pair keeps input ready for one stalled result.
// Reset (synchronous, active low) clears governor state and output valid flags and loads config defaults.
`default_nettype none

module core_hotplug_governor import hpg_pkg::*; #(
    parameter int THREAD_CAP     = 200,
    parameter int LOAD_FRAC_BITS = 11,
    parameter int IDLE_LIMIT     = 19,
    parameter int BUSY_TICKS     = 13,
    parameter int CORES          = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [AVG_W-1:0]     i_cfg_data,
    hpg_in_if.sink                    i_in,
    hpg_out_if.source                 o_out
);
    // thresholds scaled by the thread cap at elaboration
    localparam t_thr_tab THR_TAB = thr_tab(THREAD_CAP);

    // ---------------- configuration registers ----------------
    logic              r_plug_en;
    logic              r_touch_en;
    logic [PROF_W-1:0] r_profile;
    logic [HYST_W-1:0] r_hyst;
    logic [AVG_W-1:0]  r_core_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plug_en  <= 1'b1;
            r_touch_en <= 1'b1;
            r_profile  <= '0;
            r_hyst     <= HYST_W'(8);
            r_core_thr <= AVG_W'(500);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLUG_EN:  r_plug_en  <= i_cfg_data[0];
                CFG_TOUCH_EN: r_touch_en <= i_cfg_data[0];
                CFG_PROFILE:  r_profile  <= i_cfg_data[PROF_W-1:0];
                CFG_HYST:     r_hyst     <= i_cfg_data[HYST_W-1:0];
                CFG_CORE_THR: r_core_thr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- governor state ----------------
    t_gov_state r_state;
    t_gov_state n_state;
    logic       w_fire;

    assign w_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= '0;
        else if (w_fire)
            r_state <= n_state;
    end

    // lazy mode overrides the selected profile without touching the register
    logic [PROF_W-1:0] w_prof;
    logic              w_eco;

    assign w_prof = r_state.lazy_active ? r_state.lazy_profile : r_profile;
    assign w_eco  = (w_prof >= PROF_ECO);

    // ---------------- threshold lanes: one per level boundary ----------------
    logic [2:0] w_above;

    for (genvar l = 0; l < 3; l++) begin : g_lvl
        logic [THR_W-1:0] w_thr;
        logic             w_add;

        assign w_thr = THR_TAB[w_prof][l];
        // hysteresis applies when the previous level was not above this boundary
        assign w_add = (r_state.last_level <= LVL_W'(l + 1));

        hpg_lvl_lane #(
            .FRAC_BITS (LOAD_FRAC_BITS),
            .STD_SHIFT (CORES - 1)
        ) u_lane (
            .i_avg      (i_in.avg_load),
            .i_thr      (w_thr),
            .i_hyst     (r_hyst),
            .i_add_hyst (w_add),
            .i_eco      (w_eco),
            .o_above    (w_above[l])
        );
    end

    // ---------------- core lanes: cores 1..CORES-1 ----------------
    logic [AVG_W-1:0]  w_loads [1:3];
    logic [MASK_W-1:0] w_down;

    assign w_loads[1] = i_in.load_core1;
    assign w_loads[2] = i_in.load_core2;
    assign w_loads[3] = i_in.load_core3;
    assign w_down[0]  = 1'b0;   // core 0 always stays up

    for (genvar c = 1; c < MASK_W; c++) begin : g_core
        if (c < CORES) begin : g_on
            hpg_core_lane u_lane (
                .i_online (i_in.online_mask[c]),
                .i_load   (w_loads[c]),
                .i_thr    (r_core_thr),
                .o_down   (w_down[c])
            );
        end else begin : g_off
            assign w_down[c] = 1'b0;
        end
    end

    // ---------------- merge ----------------
    t_ctrl_cfg w_cfg;
    t_result   w_result;

    assign w_cfg.plug_en  = r_plug_en;
    assign w_cfg.touch_en = r_touch_en;

    hpg_ctrl #(
        .CORES      (CORES),
        .IDLE_LIMIT (IDLE_LIMIT),
        .BUSY_TICKS (BUSY_TICKS)
    ) u_ctrl (
        .i_kind   (i_in.kind),
        .i_video  (i_in.video_flag),
        .i_above  (w_above),
        .i_eco    (w_eco),
        .i_down   (w_down),
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // ---------------- output register + skid ----------------
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, r_skid;
    logic    w_take;
    logic    w_load_out, w_load_skid, w_skid_to_out;

    assign i_in.ready = !r_skid_valid;
    assign w_take     = r_out_valid && o_out.ready;

    always_comb begin
        w_skid_to_out = w_take && r_skid_valid;
        w_load_out    = w_fire && (!r_out_valid || w_take);
        w_load_skid   = w_fire && r_out_valid && !w_take;
        n_out_valid   = w_load_out || w_skid_to_out || (r_out_valid && !w_take);
        n_skid_valid  = w_load_skid || (r_skid_valid && !w_skid_to_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_skid_to_out)
            r_out <= r_skid;
        else if (w_load_out)
            r_out <= w_result;
        if (w_load_skid)
            r_skid <= w_result;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.action     = r_out.action;
    assign o_out.down_mask  = r_out.down_mask;
    assign o_out.load_level = r_out.load_level;
endmodule

`default_nettype wire
